### rtl/lnis_pkg.sv
// Shared types and constants of the integer layer normalization block.
package lnis_pkg;

   localparam int DIV_NW = 22;
   localparam int DIV_DW = 11;
   localparam int SQ_W   = 22;
   localparam int SQ_RW  = 11;

   localparam logic [1:0] DIV_SEL_MEAN = 2'd0;
   localparam logic [1:0] DIV_SEL_VAR  = 2'd1;
   localparam logic [1:0] DIV_SEL_OUT  = 2'd2;

   localparam logic [23:0] GAIN_RESET = 24'd65536;
   localparam logic signed [7:0] OUT_MAX = 8'sd127;
   localparam logic signed [7:0] OUT_MIN = -8'sd128;

   typedef struct packed {
      logic       load;
      logic       div_start;
      logic [1:0] div_sel;
      logic       mean_cap;
      logic       var1;
      logic       var2;
      logic       var3;
      logic       var_cap;
      logic       sqrt_start;
      logic       sd_cap;
      logic       idx_clear;
      logic       rd;
      logic       em1;
      logic       em2;
      logic       em3;
      logic       em4;
      logic       res_cap;
      logic       next_idx;
      logic       clear;
   } lnis_cmd_type;

   typedef struct packed {
      logic last_slot;
      logic div_done;
      logic sqrt_done;
      logic idx_last;
   } lnis_status_type;

endpackage

### rtl/layernorm_int8_integer_stats.sv
// Top level of the int8 layer normalization block with its register port.
// This block normalizes an int8 vector of up to MAX_DIM elements. Each input
// transaction carries one sample with its gamma (signed Q4.12) and beta
// (signed Q8.8, already in output units) and is buffered while a running
// sum and a sum of squares are kept. The element flagged last, or the one
// that fills the MAX_DIM-th slot, closes the vector and input stalls from
// then on. The mean and then the variance are formed by a shared 22-step
// restoring divider and the standard deviation by an 11-step square root
// unit. Every buffered element then leaves in load order as one output
// transaction, round(xc*gamma*gain/std + beta) with half away from zero and
// saturation to int8; each passes through the same divider and waits while
// the output side stalls, and the next is not begun until it is accepted.
// Input is taken again once the final output transaction, marked by
// rsp_result_last, has been accepted. The gain register (unsigned Q8.16,
// reset 1.0) lies at byte address 0 and should be written only while the
// block is idle.
module layernorm_int8_integer_stats
   import lnis_pkg::*;
#(
   parameter int MAX_DIM = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [7:0]  req_sample,
   input  logic signed [15:0] req_gamma,
   input  logic signed [15:0] req_beta,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [7:0]  rsp_result,
   output logic               rsp_result_last,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   lnis_cmd_type    cmd;
   lnis_status_type status;
   logic [23:0]     gain_ff;

   // Register port: one register, decoded on the word address bit.
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {8'd0, gain_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         gain_ff <= csr_pwdata[23:0];
      end
   end

   lnis_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last        (req_last),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_last (rsp_result_last),
      .cmd             (cmd),
      .status          (status)
   );

   lnis_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .gain   (gain_ff),
      .sample (req_sample),
      .gamma  (req_gamma),
      .beta   (req_beta),
      .result (rsp_result)
   );

endmodule

### rtl/lnis_div.sv
// Iterative restoring unsigned divider, one quotient bit per cycle.
module lnis_div
   import lnis_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_NW-1:0] num,
   input  logic [DIV_DW-1:0] den,
   output logic              done,
   output logic [DIV_NW-1:0] quot
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_NW-1:0] q_ff, q_in;
   logic [DIV_DW-1:0] den_ff, den_in;
   logic [DIV_DW:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      trial   = {rem_ff, q_ff[DIV_NW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         q_in    = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DW'(trial - {1'b0, den_ff});
            q_in   = {q_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DW-1:0];
            q_in   = {q_ff[DIV_NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(DIV_NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

### rtl/lnis_sqrt.sv
// Iterative digit-by-digit floor square root, one result bit per cycle.
module lnis_sqrt
   import lnis_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SQ_W-1:0]  value,
   output logic             done,
   output logic [SQ_RW-1:0] root
);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [3:0]      cnt_ff, cnt_in;
   logic [SQ_W-1:0] op_ff, op_in;
   logic [SQ_W-1:0] res_ff, res_in;
   logic [SQ_W-1:0] one_ff, one_in;
   logic [SQ_W-1:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      res_in  = res_ff;
      one_in  = one_ff;
      trial   = res_ff + one_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         op_in   = value;
         res_in  = '0;
         one_in  = SQ_W'(1) << (SQ_W - 2);
      end else if (busy_ff) begin
         if (op_ff >= trial) begin
            op_in  = op_ff - trial;
            res_in = (res_ff >> 1) + one_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         one_in = one_ff >> 2;
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(SQ_RW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      op_ff  <= op_in;
      res_ff <= res_in;
      one_ff <= one_in;
   end

   assign done = done_ff;
   assign root = res_ff[SQ_RW-1:0];

endmodule

### rtl/lnis_datapath.sv
// Datapath: element buffers, running sums, statistics and output arithmetic.
module lnis_datapath
   import lnis_pkg::*;
#(
   parameter int MAX_DIM = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  lnis_cmd_type        cmd,
   output lnis_status_type     status,
   input  logic [23:0]         gain,
   input  logic signed [7:0]   sample,
   input  logic signed [15:0]  gamma,
   input  logic signed [15:0]  beta,
   output logic signed [7:0]   result
);

   localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CW = $clog2(MAX_DIM + 1);

   logic signed [7:0]  sample_mem [0:MAX_DIM-1];
   logic signed [15:0] gamma_mem  [0:MAX_DIM-1];
   logic signed [15:0] beta_mem   [0:MAX_DIM-1];

   logic [CW-1:0]        count_ff;
   logic signed [14:0]   sum_ff;
   logic [20:0]          sq_ff;
   logic [AW-1:0]        idx_ff;
   logic signed [8:0]    mean_ff;
   logic signed [16:0]   t_ff;
   logic signed [26:0]   p_ff;
   logic [21:0]          vs_ff;
   logic [21:0]          variance_ff;
   logic [SQ_RW-1:0]     sd_ff;
   logic signed [7:0]    samp_rd;
   logic signed [15:0]   gam_rd;
   logic signed [15:0]   bet_rd;
   logic signed [25:0]   xg_ff;
   logic signed [15:0]   beta_ff;
   logic signed [50:0]   p1_ff;
   logic signed [27:0]   bs_ff;
   logic signed [51:0]   num_ff;
   logic [21:0]          a_ff;
   logic                 neg_ff;
   logic signed [7:0]    result_ff;

   logic signed [15:0]   sqr;
   logic [14:0]          abs_sum;
   logic signed [17:0]   u;
   logic signed [27:0]   vsw;
   logic signed [9:0]    xc;
   logic [51:0]          mag;
   logic [52:0]          a_sum;
   logic [DIV_NW-1:0]    div_num;
   logic [DIV_DW-1:0]    div_den;
   logic [DIV_NW-1:0]    quot;
   logic                 div_done;
   logic [SQ_RW-1:0]     root;
   logic                 sqrt_done;

   assign sqr     = sample * sample;
   assign abs_sum = sum_ff[14] ? 15'(-sum_ff) : 15'(sum_ff);
   assign u       = (18'(sum_ff) <<< 1) - 18'(t_ff);
   assign vsw     = $signed({7'b0, sq_ff}) - 28'(p_ff);
   assign xc      = 10'(samp_rd) - 10'(mean_ff);
   assign mag     = num_ff[51] ? 52'(-num_ff) : 52'(num_ff);
   assign a_sum   = 53'(mag) + (53'(sd_ff) << 27);

   always_comb begin
      case (cmd.div_sel)
         DIV_SEL_MEAN: begin
            div_num = DIV_NW'(abs_sum);
            div_den = DIV_DW'(count_ff);
         end
         DIV_SEL_VAR: begin
            div_num = vs_ff;
            div_den = DIV_DW'(count_ff);
         end
         DIV_SEL_OUT: begin
            div_num = a_ff;
            div_den = sd_ff;
         end
         default: begin
            div_num = a_ff;
            div_den = sd_ff;
         end
      endcase
   end

   lnis_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (quot)
   );

   lnis_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .value (variance_ff),
      .done  (sqrt_done),
      .root  (root)
   );

   // Element buffers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_mem[count_ff[AW-1:0]] <= sample;
         gamma_mem[count_ff[AW-1:0]]  <= gamma;
         beta_mem[count_ff[AW-1:0]]   <= beta;
      end
      if (cmd.rd) begin
         samp_rd <= sample_mem[idx_ff];
         gam_rd  <= gamma_mem[idx_ff];
         bet_rd  <= beta_mem[idx_ff];
      end
   end

   // Counters and running sums.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
      end else if (cmd.load) begin
         count_ff <= count_ff + CW'(1);
         sum_ff   <= sum_ff + 15'(sample);
         sq_ff    <= sq_ff + 21'(unsigned'(sqr));
      end
      if (reset || cmd.idx_clear) begin
         idx_ff <= '0;
      end else if (cmd.next_idx) begin
         idx_ff <= idx_ff + AW'(1);
      end
   end

   // Statistics and per-element arithmetic.
   always_ff @(posedge clock) begin
      if (cmd.mean_cap) begin
         mean_ff <= sum_ff[14] ? 9'(9'd0 - quot[8:0]) : $signed(quot[8:0]);
      end
      if (cmd.var1) begin
         t_ff <= $signed({1'b0, 7'(count_ff)}) * mean_ff;
      end
      if (cmd.var2) begin
         p_ff <= mean_ff * u;
      end
      if (cmd.var3) begin
         vs_ff <= vsw[21:0];
      end
      if (cmd.var_cap) begin
         variance_ff <= quot + 22'd1;
      end
      if (cmd.sd_cap) begin
         sd_ff <= (root == '0) ? SQ_RW'(1) : root;
      end
      if (cmd.em1) begin
         xg_ff   <= xc * gam_rd;
         beta_ff <= bet_rd;
      end
      if (cmd.em2) begin
         p1_ff <= xg_ff * $signed({1'b0, gain});
         bs_ff <= beta_ff * $signed({1'b0, sd_ff});
      end
      if (cmd.em3) begin
         num_ff <= 52'(p1_ff) + (52'(bs_ff) <<< 20);
      end
      if (cmd.em4) begin
         a_ff   <= a_sum[49:28];
         neg_ff <= num_ff[51];
      end
      if (cmd.res_cap) begin
         if (neg_ff) begin
            result_ff <= (quot > 22'd128) ? OUT_MIN : 8'(22'd0 - quot);
         end else begin
            result_ff <= (quot > 22'd127) ? OUT_MAX : 8'(quot);
         end
      end
   end

   assign status.last_slot = (count_ff == CW'(MAX_DIM - 1));
   assign status.div_done  = div_done;
   assign status.sqrt_done = sqrt_done;
   assign status.idx_last  = ((CW'(idx_ff) + CW'(1)) == count_ff);
   assign result           = result_ff;

endmodule

### rtl/lnis_ctrl.sv
// Controller state machine that sequences loading, statistics and emission.
module lnis_ctrl
   import lnis_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_last,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic            rsp_result_last,
   output lnis_cmd_type    cmd,
   input  lnis_status_type status
);

   localparam logic [4:0] S_LOAD  = 5'd0;
   localparam logic [4:0] S_MDIV  = 5'd1;
   localparam logic [4:0] S_MWAIT = 5'd2;
   localparam logic [4:0] S_VAR1  = 5'd3;
   localparam logic [4:0] S_VAR2  = 5'd4;
   localparam logic [4:0] S_VAR3  = 5'd5;
   localparam logic [4:0] S_VDIV  = 5'd6;
   localparam logic [4:0] S_VWAIT = 5'd7;
   localparam logic [4:0] S_SWAIT = 5'd8;
   localparam logic [4:0] S_RD    = 5'd9;
   localparam logic [4:0] S_EM1   = 5'd10;
   localparam logic [4:0] S_EM2   = 5'd11;
   localparam logic [4:0] S_EM3   = 5'd12;
   localparam logic [4:0] S_EM4   = 5'd13;
   localparam logic [4:0] S_EDIV  = 5'd14;
   localparam logic [4:0] S_EWAIT = 5'd15;
   localparam logic [4:0] S_OUT   = 5'd16;

   logic [4:0] state_ff, state_in;
   logic       last_ff, last_in;
   logic       sqrt_go_ff, sqrt_go_in;

   assign sqrt_go_in = (state_ff == S_VWAIT) && status.div_done;

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      cmd      = '0;
      cmd.div_sel = DIV_SEL_OUT;
      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last || status.last_slot) begin
                  state_in = S_MDIV;
               end
            end
         end
         S_MDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_MEAN;
            state_in      = S_MWAIT;
         end
         S_MWAIT: begin
            if (status.div_done) begin
               cmd.mean_cap = 1'b1;
               state_in     = S_VAR1;
            end
         end
         S_VAR1: begin
            cmd.var1 = 1'b1;
            state_in = S_VAR2;
         end
         S_VAR2: begin
            cmd.var2 = 1'b1;
            state_in = S_VAR3;
         end
         S_VAR3: begin
            cmd.var3 = 1'b1;
            state_in = S_VDIV;
         end
         S_VDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_VAR;
            state_in      = S_VWAIT;
         end
         S_VWAIT: begin
            if (status.div_done) begin
               cmd.var_cap = 1'b1;
               state_in    = S_SWAIT;
            end
         end
         S_SWAIT: begin
            // The root unit starts on the cycle after the variance lands.
            cmd.sqrt_start = sqrt_go_ff;
            if (status.sqrt_done) begin
               cmd.sd_cap    = 1'b1;
               cmd.idx_clear = 1'b1;
               state_in      = S_RD;
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_EM1;
         end
         S_EM1: begin
            cmd.em1  = 1'b1;
            state_in = S_EM2;
         end
         S_EM2: begin
            cmd.em2  = 1'b1;
            state_in = S_EM3;
         end
         S_EM3: begin
            cmd.em3  = 1'b1;
            state_in = S_EM4;
         end
         S_EM4: begin
            cmd.em4  = 1'b1;
            state_in = S_EDIV;
         end
         S_EDIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_EWAIT;
         end
         S_EWAIT: begin
            if (status.div_done) begin
               cmd.res_cap = 1'b1;
               last_in     = status.idx_last;
               state_in    = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               if (last_ff) begin
                  cmd.clear = 1'b1;
                  state_in  = S_LOAD;
               end else begin
                  cmd.next_idx = 1'b1;
                  state_in     = S_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         last_ff    <= 1'b0;
         sqrt_go_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         last_ff    <= last_in;
         sqrt_go_ff <= sqrt_go_in;
      end
   end

   assign req_stall       = (state_ff != S_LOAD);
   assign rsp_valid       = (state_ff == S_OUT);
   assign rsp_result_last = last_ff;

endmodule

### tb/layernorm_int8_integer_stats_test.sv
// Self-checking testbench of the int8 layer normalization block with its gain register.
module layernorm_int8_integer_stats_test
   import lnis_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int VEC_MAX = 64;
   localparam longint CYCLE_LIMIT = 200000;

   // One input element as the sender sees it.
   typedef struct packed {
      logic signed [7:0]  sample;
      logic signed [15:0] gamma;
      logic signed [15:0] beta;
      logic               last;
   } element_type;

   // One normalized output element.
   typedef struct packed {
      logic signed [7:0] result;
      logic              result_last;
   } norm_out_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [7:0]  req_sample = '0;
   logic signed [15:0] req_gamma = '0;
   logic signed [15:0] req_beta = '0;
   logic               req_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [7:0]  rsp_result;
   logic               rsp_result_last;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   layernorm_int8_integer_stats u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_sample(req_sample), .req_gamma(req_gamma), .req_beta(req_beta),
      .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result(rsp_result), .rsp_result_last(rsp_result_last),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #2 clock = ~clock;

   // Mirror of the block's state, used to predict the normalized outputs.
   element_type      vec_buf[VEC_MAX];
   int               vec_len = 0;
   logic [23:0]      gain_q = GAIN_RESET;
   element_type      pending_elems[$];
   norm_out_type     expected_outputs[$];
   int               error_count = 0;
   longint           cycle_count = 0;
   bit               no_idle = 1'b0;
   bit               hold_sender = 1'b0;

   task automatic report_mismatch(input string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic longint floor_root(input longint n);
      longint lo, hi, mid, root;
      lo = 0;
      hi = 46342;
      root = 0;
      if (n <= 0) return 0;
      while (lo <= hi) begin
         mid = (lo + hi) >>> 1;
         if (mid * mid == n) return mid;
         if (mid * mid < n) begin
            root = mid;
            lo = mid + 1;
         end else begin
            hi = mid - 1;
         end
      end
      return root;
   endfunction

   // Buffers one element; on the closing element it predicts the whole vector.
   task automatic normalize_element(input element_type e);
      longint sum, sq_sum, n, mean, var_sum, sd, den, xc, num, mag, q;
      norm_out_type o;
      int slot;
      slot = (vec_len >= VEC_MAX) ? VEC_MAX - 1 : vec_len;
      vec_buf[slot] = e;
      vec_len = slot + 1;
      if (!(e.last || vec_len >= VEC_MAX)) return;
      sum = 0;
      sq_sum = 0;
      for (int i = 0; i < vec_len; i++) begin
         sum += longint'(vec_buf[i].sample);
         sq_sum += longint'(vec_buf[i].sample) * longint'(vec_buf[i].sample);
      end
      n = vec_len;
      mean = sum / n;
      var_sum = sq_sum - 2 * mean * sum + n * mean * mean;
      sd = floor_root(var_sum / n + 1);
      if (sd <= 0) sd = 1;
      den = sd <<< 28;
      for (int i = 0; i < vec_len; i++) begin
         xc = longint'(vec_buf[i].sample) - mean;
         num = xc * longint'(vec_buf[i].gamma) * longint'({1'b0, gain_q})
               + longint'(vec_buf[i].beta) * sd * (longint'(1) <<< 20);
         mag = (num < 0) ? -num : num;
         q = (mag + den / 2) / den;
         if (num < 0) o.result = (q > 128) ? OUT_MIN : 8'(-q);
         else         o.result = (q > 127) ? OUT_MAX : 8'(q);
         o.result_last = (i + 1 == vec_len);
         expected_outputs.push_back(o);
      end
      vec_len = 0;
   endtask

   // Driver: presents queued elements and output stalls, at random unless told not to.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (!req_valid || !req_stall) begin
            if (pending_elems.size() > 0 && !hold_sender &&
                (no_idle || $urandom_range(99) >= 16)) begin
               element_type e;
               e = pending_elems.pop_front();
               req_valid  <= 1'b1;
               req_sample <= e.sample;
               req_gamma  <= e.gamma;
               req_beta   <= e.beta;
               req_last   <= e.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 16);
      end
   end

   // Predict at the accepting edge, from the payload that was accepted.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         normalize_element({req_sample, req_gamma, req_beta, req_last});
   end

   // Monitor: every accepted output transaction meets the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected output %0d", rsp_result));
         end else begin
            norm_out_type exp_o;
            exp_o = expected_outputs.pop_front();
            if (rsp_result !== exp_o.result)
               report_mismatch($sformatf("result %0d, expected %0d",
                                         rsp_result, exp_o.result));
            if (rsp_result_last !== exp_o.result_last)
               report_mismatch($sformatf("result_last %0b, expected %0b",
                                         rsp_result_last, exp_o.result_last));
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("layernorm_int8_integer_stats_test: FAIL");
         $finish;
      end
   end

   function automatic element_type rand_element(input bit last);
      element_type e;
      e.sample = 8'($urandom);
      e.gamma  = 16'($urandom);
      e.beta   = 16'($urandom);
      e.last   = last;
      return e;
   endfunction

   task automatic queue_vector(input int len);
      for (int i = 0; i < len; i++) pending_elems.push_back(rand_element(i == len - 1));
   endtask

   // Waits until every queued element is taken and every output has arrived.
   task automatic drain();
      while (pending_elems.size() > 0 || req_valid || expected_outputs.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_gain(input logic [23:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'd0;
      csr_pwdata  <= {8'hA5, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      gain_q = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [23:0] gains[5] = '{24'd65536, 24'd0, 24'hFFFFFF, 24'd1, 24'd300000};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes of every field, one-element, zero-variance and alternating
      // vectors, and an overflow vector whose 64th element closes it with no last.
      pending_elems.push_back('{8'sh7F, 16'sh7FFF, 16'sh7FFF, 1'b0});
      pending_elems.push_back('{8'sh80, 16'sh8000, 16'sh8000, 1'b0});
      pending_elems.push_back('{8'sh00, 16'sh0000, 16'sh0000, 1'b0});
      pending_elems.push_back('{8'shFF, 16'shFFFF, 16'shFFFF, 1'b1});
      pending_elems.push_back('{8'sh55, 16'sh1000, 16'sh0080, 1'b1});
      for (int i = 0; i < 6; i++) pending_elems.push_back('{8'sh33, 16'sh1000, 16'sh0000, i == 5});
      for (int i = 0; i < 4; i++) pending_elems.push_back('{(i[0] ? 8'sh7F : 8'sh80), 16'sh7FFF, 16'sh0000, i == 3});
      drain();
      write_gain(24'hFFFFFF);
      queue_vector(VEC_MAX + 3);
      for (int i = 0; i < 2; i++) pending_elems[VEC_MAX - 1 + i].last = 1'b0;
      drain();

      // Random vectors under several gains; one phase runs without idling, and
      // in another the sender holds off midway until all outputs are back.
      for (int p = 0; p < 5; p++) begin
         write_gain(gains[p]);
         no_idle = (p == 2);
         while (pending_elems.size() < 50) queue_vector($urandom_range(1, (p == 3) ? 64 : 12));
         if (p == 1) begin
            while (pending_elems.size() > 25) @(posedge clock);
            hold_sender = 1'b1;
            while (expected_outputs.size() > 0 || req_valid) @(posedge clock);
            hold_sender = 1'b0;
         end
         drain();
      end
      write_gain(GAIN_RESET);
      queue_vector(5);
      drain();

      if (error_count == 0 && expected_outputs.size() == 0) begin
         $display("layernorm_int8_integer_stats_test: PASS");
      end else begin
         $display("layernorm_int8_integer_stats_test: FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/lnis_pkg.sv
rtl/lnis_div.sv
rtl/lnis_sqrt.sv
rtl/lnis_datapath.sv
rtl/lnis_ctrl.sv
rtl/layernorm_int8_integer_stats.sv
tb/layernorm_int8_integer_stats_test.sv
